FILE: src/pbd_pkg.sv
// pbd_pkg: shared types and constants for the pulse beat detector.
// No dependencies; every other file in src uses it by scoped names.
package pbd_pkg;

   // sample/threshold, count, rate and window code widths, full-scale code
   localparam int unsigned SAMPLE_W = 10;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned RATE_W   = 19;
   localparam int unsigned WCODE_W  = 3;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 10'h3ff;

   // register file layout
   localparam int unsigned ADDR_W = 4;
   localparam int unsigned DATA_W = 32;
   localparam logic [1:0] REG_SWING_LIMIT = 2'd0;
   localparam logic [1:0] REG_LOW_LIMIT   = 2'd1;
   localparam logic [1:0] REG_WINDOW_CODE = 2'd2;

   // register reset values
   localparam logic [SAMPLE_W-1:0] SWING_LIMIT_RST = 10'd500;
   localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RST   = 10'd100;

   // window codes and their rate multipliers
   localparam logic [WCODE_W-1:0] WIN_X1 = 3'd0;
   localparam logic [WCODE_W-1:0] WIN_X2 = 3'd1;
   localparam logic [WCODE_W-1:0] WIN_X3 = 3'd2;
   localparam logic [WCODE_W-1:0] WIN_X4 = 3'd3;
   localparam logic [WCODE_W-1:0] WIN_X6 = 3'd4;

   typedef struct packed {
      logic [SAMPLE_W-1:0] swing_limit;
      logic [SAMPLE_W-1:0] low_limit;
      logic [WCODE_W-1:0]  window_code;
   } cfg_type;

   typedef struct packed {
      logic                beat;
      logic [COUNT_W-1:0]  beat_count;
      logic [RATE_W-1:0]   scaled_rate;
      logic [SAMPLE_W-1:0] current_threshold;
   } result_type;

   typedef struct packed {
      logic               rise_seen;
      logic               fall_seen;
      logic [COUNT_W-1:0] beats;
   } status_type;

endpackage

FILE: src/pbd_csr.sv
// pbd_csr: APB-style register file holding swing limit, low limit and window code.
// Depends on pbd_pkg for the register layout and configuration struct.
module pbd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pbd_pkg::ADDR_W-1:0]  paddr,
   input  logic [pbd_pkg::DATA_W-1:0]  pwdata,
   output logic [pbd_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output pbd_pkg::cfg_type            cfg
);

   pbd_pkg::cfg_type cfg_ff;
   pbd_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   // decode a write word into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            pbd_pkg::REG_SWING_LIMIT: cfg_in.swing_limit = pwdata[pbd_pkg::SAMPLE_W-1:0];
            pbd_pkg::REG_LOW_LIMIT:   cfg_in.low_limit   = pwdata[pbd_pkg::SAMPLE_W-1:0];
            pbd_pkg::REG_WINDOW_CODE: cfg_in.window_code = pwdata[pbd_pkg::WCODE_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swing_limit <= pbd_pkg::SWING_LIMIT_RST;
         cfg_ff.low_limit   <= pbd_pkg::LOW_LIMIT_RST;
         cfg_ff.window_code <= pbd_pkg::WIN_X6;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, zero-extended
   always_comb begin
      unique case (reg_idx)
         pbd_pkg::REG_SWING_LIMIT:
            prdata = {{(pbd_pkg::DATA_W-pbd_pkg::SAMPLE_W){1'b0}}, cfg_ff.swing_limit};
         pbd_pkg::REG_LOW_LIMIT:
            prdata = {{(pbd_pkg::DATA_W-pbd_pkg::SAMPLE_W){1'b0}}, cfg_ff.low_limit};
         pbd_pkg::REG_WINDOW_CODE:
            prdata = {{(pbd_pkg::DATA_W-pbd_pkg::WCODE_W){1'b0}}, cfg_ff.window_code};
         default:
            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/pbd_core.sv
// pbd_core: detector state (previous sample, trough, threshold, flags, beat count)
// and the single-pass next-state and result logic. Depends on pbd_pkg.
module pbd_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [pbd_pkg::SAMPLE_W-1:0]  sample,
   input  pbd_pkg::cfg_type              cfg,
   output pbd_pkg::result_type           result,
   output pbd_pkg::status_type           status
);

   // the peak is the rising sample itself, so it needs no register here
   logic [pbd_pkg::SAMPLE_W-1:0] prev_ff,   prev_in;
   logic [pbd_pkg::SAMPLE_W-1:0] trough_ff, trough_in;
   logic [pbd_pkg::SAMPLE_W-1:0] thr_ff,    thr_in;
   logic                         rise_ff,   rise_in;
   logic                         fall_ff,   fall_in;
   logic [pbd_pkg::COUNT_W-1:0]  beats_ff,  beats_in;

   logic                         rising;
   logic                         falling;
   logic                         rise_set;
   logic                         fall_set;
   logic                         rise_tmp;
   logic                         fall_tmp;
   logic                         beat;
   logic [pbd_pkg::SAMPLE_W-1:0] swing;
   logic [pbd_pkg::RATE_W-1:0]   beats_wide;
   logic [pbd_pkg::RATE_W-1:0]   scaled;

   always_comb begin
      rising  = prev_ff < sample;
      falling = prev_ff > sample;
      swing   = sample - trough_ff;

      // adapt threshold on a rising sample
      thr_in = thr_ff;
      if (rising) begin
         if ((sample > trough_ff) && (swing > cfg.swing_limit)) begin
            thr_in = sample >> 1;
         end else begin
            thr_in = pbd_pkg::FULL_SCALE;
         end
      end
      trough_in = falling ? sample : trough_ff;
      prev_in   = sample;

      // rise phase takes priority over fall phase
      rise_set = rising && (sample >= thr_in);
      fall_set = !rise_set && falling && (sample < cfg.low_limit);
      rise_tmp = rise_ff | rise_set;
      fall_tmp = (fall_ff | fall_set) & rise_tmp;

      // complete a beat when both phases are seen
      beat     = rise_tmp & fall_tmp;
      beats_in = beats_ff + {{(pbd_pkg::COUNT_W-1){1'b0}}, beat};
      rise_in  = rise_tmp & ~beat;
      fall_in  = fall_tmp & ~beat;
   end

   // scale by window multiplier with shifts and adds
   always_comb begin
      beats_wide = {{(pbd_pkg::RATE_W-pbd_pkg::COUNT_W){1'b0}}, beats_in};
      case (cfg.window_code)
         pbd_pkg::WIN_X1: scaled = beats_wide;
         pbd_pkg::WIN_X2: scaled = beats_wide << 1;
         pbd_pkg::WIN_X3: scaled = beats_wide + (beats_wide << 1);
         pbd_pkg::WIN_X4: scaled = beats_wide << 2;
         pbd_pkg::WIN_X6: scaled = (beats_wide << 1) + (beats_wide << 2);
         default:         scaled = '0;
      endcase
   end

   // advance state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         trough_ff <= '0;
         thr_ff    <= pbd_pkg::FULL_SCALE;
         rise_ff   <= 1'b0;
         fall_ff   <= 1'b0;
         beats_ff  <= '0;
      end else if (accept) begin
         prev_ff   <= prev_in;
         trough_ff <= trough_in;
         thr_ff    <= thr_in;
         rise_ff   <= rise_in;
         fall_ff   <= fall_in;
         beats_ff  <= beats_in;
      end
   end

   assign result.beat              = beat;
   assign result.beat_count        = beats_in;
   assign result.scaled_rate       = scaled;
   assign result.current_threshold = thr_in;

   assign status.rise_seen = rise_ff;
   assign status.fall_seen = fall_ff;
   assign status.beats     = beats_ff;

endmodule

FILE: src/pulse_beat_detector.sv
// pulse_beat_detector: top level with the request/response channels and result register.
// Depends on pbd_pkg, pbd_csr and pbd_core.
//
// Usage:
//   req channel carries one 10-bit pulse sample per word (req_valid/req_ready).
//   rsp channel returns one word per sample: beat flag, beat count, count times
//   the window multiplier, and the rise threshold in force (rsp_valid/rsp_ready).
//   The APB-style port (psel .. pready) holds swing limit (0x0), low limit (0x4)
//   and window code (0x8); pready is always high, writes take setup and access.
// Output: the result word is registered and appears in the cycle after its sample is accepted.
// Throughput: one sample per cycle while no result waits on a low rsp_ready; the
//   detector state and result are computed in a single pass from the sample and
//   the state registers into the result register.
// Stall: while a result waits and rsp_ready is low, req_ready is low; when the
//   result is taken in a cycle, a new sample is accepted in that same cycle.
// Reset: synchronous, active high; clears detector state (threshold at full scale, prior
//   sample and trough at zero), drops any pending result and restores register defaults.
module pulse_beat_detector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pbd_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_beat,
   output logic [pbd_pkg::COUNT_W-1:0]   rsp_beat_count,
   output logic [pbd_pkg::RATE_W-1:0]    rsp_scaled_rate,
   output logic [pbd_pkg::SAMPLE_W-1:0]  rsp_current_threshold,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pbd_pkg::ADDR_W-1:0]    paddr,
   input  logic [pbd_pkg::DATA_W-1:0]    pwdata,
   output logic [pbd_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   pbd_pkg::cfg_type    cfg;
   pbd_pkg::result_type result;
   pbd_pkg::status_type status;
   pbd_pkg::result_type rsp_ff;
   logic                rsp_valid_ff;
   logic                accept;

   pbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pbd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sample (req_sample),
      .cfg    (cfg),
      .result (result),
      .status (status)
   );

   // take a new word when the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   // result payload, loaded with each accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_beat              = rsp_ff.beat;
   assign rsp_beat_count        = rsp_ff.beat_count;
   assign rsp_scaled_rate       = rsp_ff.scaled_rate;
   assign rsp_current_threshold = rsp_ff.current_threshold;

   // an accepted sample always yields a result in the next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted sample produced no result");

   // the reported count advances by exactly the beat flag
   a_count_tracks_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_beat_count ==
                  $past(status.beats) + {{(pbd_pkg::COUNT_W-1){1'b0}}, rsp_beat}))
      else $error("beat count does not match beat flag");

   // the fall flag is only held while the rise flag is set
   a_fall_needs_rise: assert property (@(posedge clock) disable iff (reset)
      !status.rise_seen |-> !status.fall_seen)
      else $error("fall flag set without rise flag");

endmodule
